### rtl/dpfm_pkg.sv
// Package for the demand paging frame manager: sizes, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package dpfm_pkg;
  localparam int NUM_PROCESSES = 8;
  localparam int PAGES_PER_PROCESS = 256;
  localparam int NUM_FRAMES = 16;
  localparam int PID_W = $clog2(NUM_PROCESSES);
  localparam int PAGE_W = $clog2(PAGES_PER_PROCESS);
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int ENTRY_W = PID_W + PAGE_W;
  localparam int NUM_ENTRIES = NUM_PROCESSES * PAGES_PER_PROCESS;
  localparam int FCNT_W = FRAME_W + 1;

  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_PERM = 2'd1;
  localparam logic [1:0] REQ_FREE = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXEC = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU = 2'd1;
  localparam logic [1:0] POL_NONE = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_PAGE_SIZE = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_FAULT_FREE = 3'd1;
  localparam logic [2:0] ST_FAULT_EVICT = 3'd2;
  localparam logic [2:0] ST_PROT = 3'd3;
  localparam logic [2:0] ST_NO_VICTIM = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] proc_id;
    logic [7:0] virtual_page;
    logic [1:0] access_kind;
    logic perm_read;
    logic perm_write;
    logic perm_execute;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] frame;
    logic [19:0] phys_address;
    logic evicted_valid;
    logic [2:0] evicted_process;
    logic [7:0] evicted_page;
    logic [31:0] fault_count;
  } rsp_t;

  // token that walks the frame chain during a scan
  typedef struct packed {
    logic free_found;
    logic [FRAME_W-1:0] free_idx;
    logic vic_found;
    logic [FRAME_W-1:0] vic_idx;
    logic [31:0] vic_stamp;
    logic [PID_W-1:0] vic_pid;
    logic [PAGE_W-1:0] vic_page;
  } scan_t;

  // command broadcast from the controller to every frame cell
  typedef struct packed {
    logic install;
    logic [FRAME_W-1:0] inst_idx;
    logic [PID_W-1:0] inst_pid;
    logic [PAGE_W-1:0] inst_page;
    logic touch;
    logic [FRAME_W-1:0] touch_idx;
    logic [31:0] stamp;
    logic free_pid;
    logic [PID_W-1:0] pid;
    logic lru;
    logic [FCNT_W-1:0] nframes;
  } cmd_t;
endpackage

### rtl/dpfm_if.sv
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on dpfm_pkg.
`timescale 1ns / 1ps
interface dpfm_req_if;
  import dpfm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dpfm_rsp_if;
  import dpfm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/dpfm_cell.sv
// One frame cell: owner, load and use stamps, and one step of the scan chain.
// Depends on dpfm_pkg.
`timescale 1ns / 1ps
module dpfm_cell (
  input  logic clk,
  input  logic rst,
  input  logic [dpfm_pkg::FRAME_W-1:0] idx,
  input  dpfm_pkg::cmd_t cmd,
  input  dpfm_pkg::scan_t scan_in,
  output dpfm_pkg::scan_t scan_out
);
  import dpfm_pkg::*;
  logic valid;
  logic [PID_W-1:0] pid;
  logic [PAGE_W-1:0] page;
  logic [31:0] load_stamp;
  logic [31:0] last_use;
  logic [31:0] s;
  logic active;
  scan_t nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      load_stamp <= '0;
      last_use <= '0;
    end else begin
      if (cmd.install && cmd.inst_idx == idx) begin
        valid <= 1'b1;
        pid <= cmd.inst_pid;
        page <= cmd.inst_page;
        load_stamp <= cmd.stamp;
        last_use <= cmd.stamp;
      end else if (cmd.touch && cmd.touch_idx == idx) begin
        last_use <= cmd.stamp;
      end else if (cmd.free_pid && valid && pid == cmd.pid) begin
        valid <= 1'b0;
        pid <= '0;
        page <= '0;
      end
    end
  end

  always_comb begin
    active = {1'b0, idx} < cmd.nframes;
    s = cmd.lru ? last_use : load_stamp;
    nxt = scan_in;
    if (active) begin
      if (!valid && !scan_in.free_found) begin
        nxt.free_found = 1'b1;
        nxt.free_idx = idx;
      end
      if (!scan_in.vic_found || s < scan_in.vic_stamp) begin
        nxt.vic_found = 1'b1;
        nxt.vic_idx = idx;
        nxt.vic_stamp = s;
        nxt.vic_pid = pid;
        nxt.vic_page = page;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= nxt;
  end
endmodule

### rtl/demand_paging_frame_manager.sv
// Top level of the demand paging frame manager: page table memory, controller
// and the chain of frame cells. Depends on dpfm_pkg, dpfm_if and dpfm_cell.
//   channel | dir | transaction
//   req     | in  | one request (access, set permissions, free process)
//   rsp     | out | one result per request
//   cfg     | in  | register write, no handshake
// A hit, protection fault or permission update passes S_READ, S_DECIDE and
// S_OUT; a fault also waits out the 16-cell frame chain in S_SCAN, then goes
// to S_EVICT if a frame was found. A free process sweeps its 256 page entries,
// one a cycle. A clearing pass after reset empties all 2048 entries; no request
// is taken until it ends. A stalled result holds in the output register while
// the next request runs; that request waits in its last state until it leaves.
`timescale 1ns / 1ps
module demand_paging_frame_manager (
  input  logic clk,
  input  logic rst,
  dpfm_req_if.sink req,
  dpfm_rsp_if.source rsp,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data
);
  import dpfm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_SCAN, S_EVICT, S_FREE, S_OUT
  } state_t;

  typedef struct packed {
    logic valid;
    logic r;
    logic w;
    logic x;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  state_t state;
  pte_t mem [NUM_ENTRIES];
  pte_t rd;
  logic mem_we;
  logic [ENTRY_W-1:0] mem_waddr;
  logic [ENTRY_W-1:0] mem_raddr;
  pte_t mem_wdata;
  logic [ENTRY_W:0] sweep;
  logic [1:0] policy;
  logic [16:0] page_size;
  logic [4:0] frames_cfg;
  logic [31:0] use_counter;
  logic [31:0] fault_counter;
  req_t cur;
  rsp_t out;
  rsp_t result;
  logic out_valid;
  logic [4:0] wait_cnt;
  cmd_t cmd;
  scan_t chain [NUM_FRAMES+1];
  logic [FCNT_W-1:0] nframes;
  logic [FRAME_W-1:0] res_frame;
  logic [36:0] prod;
  logic ok;

  assign nframes = (frames_cfg > 5'(NUM_FRAMES)) ? FCNT_W'(NUM_FRAMES) : FCNT_W'(frames_cfg);
  assign chain[0] = '0;
  assign mem_raddr = {cur.proc_id[PID_W-1:0], cur.virtual_page[PAGE_W-1:0]};
  assign prod = 37'(res_frame) * 37'(page_size);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[mem_raddr];
  end

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    dpfm_cell u_cell (
      .clk(clk), .rst(rst), .idx(FRAME_W'(i)), .cmd(cmd),
      .scan_in(chain[i]), .scan_out(chain[i+1])
    );
  end

  always_comb begin
    unique case (cur.access_kind)
      KIND_READ: ok = rd.r;
      KIND_WRITE: ok = rd.w;
      KIND_EXEC: ok = rd.x;
      default: ok = 1'b0;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIFO;
      page_size <= 17'd4096;
      frames_cfg <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy <= cfg_data[1:0];
        REG_PAGE_SIZE: page_size <= cfg_data;
        REG_FRAMES: frames_cfg <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mem_we <= 1'b0;
    cmd.install <= 1'b0;
    cmd.touch <= 1'b0;
    cmd.free_pid <= 1'b0;
    cmd.lru <= (policy == POL_LRU);
    cmd.nframes <= nframes;
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      use_counter <= '0;
      fault_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          mem_we <= 1'b1;
          mem_waddr <= sweep[ENTRY_W-1:0];
          mem_wdata <= '0;
          sweep <= sweep + 1'b1;
          if (sweep[ENTRY_W-1:0] == ENTRY_W'(NUM_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            state <= S_READ;
          end
        end
        S_READ: state <= S_DECIDE;
        S_DECIDE: begin
          out <= '0;
          out.fault_count <= fault_counter;
          out.status <= ST_DONE;
          state <= S_OUT;
          res_frame <= '0;
          if (cur.req_type == REQ_ACCESS) begin
            if (rd.valid) begin
              if (!ok) out.status <= ST_PROT;
              else begin
                out.status <= ST_HIT;
                res_frame <= rd.frame;
                cmd.touch <= 1'b1;
                cmd.touch_idx <= rd.frame;
                cmd.stamp <= use_counter;
                if (use_counter != '1) use_counter <= use_counter + 1'b1;
              end
            end else begin
              if (fault_counter != '1) fault_counter <= fault_counter + 1'b1;
              wait_cnt <= '0;
              state <= S_SCAN;
            end
          end else if (cur.req_type == REQ_PERM) begin
            mem_we <= 1'b1;
            mem_waddr <= mem_raddr;
            mem_wdata <= '{valid: rd.valid, r: cur.perm_read, w: cur.perm_write,
                           x: cur.perm_execute, frame: rd.frame};
          end else if (cur.req_type == REQ_FREE) begin
            cmd.free_pid <= 1'b1;
            cmd.pid <= cur.proc_id[PID_W-1:0];
            sweep <= '0;
            state <= S_FREE;
          end
        end
        S_SCAN: begin
          out.fault_count <= fault_counter;
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 5'(NUM_FRAMES + 1)) begin
            if (chain[NUM_FRAMES].free_found || (policy <= POL_LRU &&
                chain[NUM_FRAMES].vic_found)) begin
              if (chain[NUM_FRAMES].free_found) begin
                res_frame <= chain[NUM_FRAMES].free_idx;
                cmd.inst_idx <= chain[NUM_FRAMES].free_idx;
                out.status <= ST_FAULT_FREE;
              end else begin
                res_frame <= chain[NUM_FRAMES].vic_idx;
                cmd.inst_idx <= chain[NUM_FRAMES].vic_idx;
                out.status <= ST_FAULT_EVICT;
                out.evicted_valid <= 1'b1;
                out.evicted_process <= 3'(chain[NUM_FRAMES].vic_pid);
                out.evicted_page <= 8'(chain[NUM_FRAMES].vic_page);
                mem_we <= 1'b1;
                mem_waddr <= {chain[NUM_FRAMES].vic_pid, chain[NUM_FRAMES].vic_page};
                mem_wdata <= '0;
              end
              cmd.install <= 1'b1;
              cmd.inst_pid <= cur.proc_id[PID_W-1:0];
              cmd.inst_page <= cur.virtual_page[PAGE_W-1:0];
              cmd.stamp <= use_counter;
              if (use_counter != '1) use_counter <= use_counter + 1'b1;
              state <= S_EVICT;
            end else begin
              out.status <= ST_NO_VICTIM;
              state <= S_OUT;
            end
          end
        end
        S_EVICT: begin
          mem_we <= 1'b1;
          mem_waddr <= mem_raddr;
          mem_wdata <= '{valid: 1'b1, r: 1'b1, w: 1'b1, x: 1'b0, frame: res_frame};
          state <= S_OUT;
        end
        S_FREE: begin
          mem_we <= 1'b1;
          mem_waddr <= {cur.proc_id[PID_W-1:0], sweep[PAGE_W-1:0]};
          mem_wdata <= '0;
          sweep <= sweep + 1'b1;
          if (sweep[PAGE_W-1:0] == PAGE_W'(PAGES_PER_PROCESS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            result <= '{status: out.status,
                        frame: (out.status <= ST_FAULT_EVICT) ? 4'(res_frame) : 4'd0,
                        phys_address: (out.status <= ST_FAULT_EVICT) ? prod[19:0] : 20'd0,
                        evicted_valid: out.evicted_valid,
                        evicted_process: out.evicted_process,
                        evicted_page: out.evicted_page,
                        fault_count: out.fault_count};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> (out_valid && $stable(result)))
    else $error("result changed under stall");
  a_fault_mono: assert property (@(posedge clk) disable iff (rst)
    $past(fault_counter) <= fault_counter || $past(rst))
    else $error("fault counter went back");
endmodule

### verif/dpfm_tb_if.sv
// Testbench constants: clock period.
// No dependencies.
`timescale 1ns / 1ps
package dpfm_tb_pkg;
  localparam int PERIOD_NS = 10;
endpackage

### verif/tb_top.sv
// Testbench for the demand paging frame manager: directed and random requests,
// a predictor of page table and frame state, and an in-order result check.
// Depends on dpfm_pkg, dpfm_tb_pkg, dpfm_if and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import dpfm_pkg::*;
  import dpfm_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_POLICY;
  logic [16:0] cfg_data = '0;

  dpfm_req_if req_ch();
  dpfm_rsp_if rsp_ch();

  demand_paging_frame_manager dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(PERIOD_NS / 2) clk = ~clk;

  // predictor state
  logic pe_valid [NUM_ENTRIES];
  logic pe_r [NUM_ENTRIES];
  logic pe_w [NUM_ENTRIES];
  logic pe_x [NUM_ENTRIES];
  logic [3:0] pe_frame [NUM_ENTRIES];
  logic fo_valid [NUM_FRAMES];
  logic [2:0] fo_pid [NUM_FRAMES];
  logic [7:0] fo_page [NUM_FRAMES];
  logic [31:0] last_use [NUM_FRAMES];
  logic [31:0] load_stamp [NUM_FRAMES];
  logic [31:0] use_ctr, fault_ctr;
  logic [1:0] policy;
  logic [16:0] pg_size;
  logic [4:0] nframes_reg;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int errors = 0;
  int accepted = 0, checked = 0, evictions = 0, prot_faults = 0;
  bit src_idle_en = 1, snk_idle_en = 1, hold = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic load_page(int f, logic [2:0] pid, logic [7:0] pg);
    int idx;
    idx = int'({pid, pg});
    fo_valid[f] = 1'b1; fo_pid[f] = pid; fo_page[f] = pg;
    pe_valid[idx] = 1'b1; pe_r[idx] = 1'b1; pe_w[idx] = 1'b1; pe_x[idx] = 1'b0;
    pe_frame[idx] = 4'(f);
    last_use[f] = use_ctr; load_stamp[f] = use_ctr;
    use_ctr = sat_inc(use_ctr);
  endtask

  task automatic predict_paging(req_t r);
    rsp_t o;
    int idx, n, f, vic, vidx;
    logic ok, found;
    logic [31:0] best, s;
    o = '0;
    o.status = ST_DONE;
    idx = int'({r.proc_id, r.virtual_page});
    n = (nframes_reg > 5'(NUM_FRAMES)) ? NUM_FRAMES : int'(nframes_reg);
    if (r.req_type == REQ_ACCESS) begin
      if (pe_valid[idx]) begin
        case (r.access_kind)
          KIND_READ: ok = pe_r[idx];
          KIND_WRITE: ok = pe_w[idx];
          KIND_EXEC: ok = pe_x[idx];
          default: ok = 1'b0;
        endcase
        if (!ok) o.status = ST_PROT;
        else begin
          o.frame = pe_frame[idx];
          last_use[o.frame] = use_ctr;
          use_ctr = sat_inc(use_ctr);
          o.status = ST_HIT;
        end
      end else begin
        fault_ctr = sat_inc(fault_ctr);
        found = 1'b0; vic = -1; best = '0;
        for (f = 0; f < n && !found; f++) if (!fo_valid[f]) begin
          found = 1'b1; vic = f;
        end
        if (found) begin
          load_page(vic, r.proc_id, r.virtual_page);
          o.frame = 4'(vic); o.status = ST_FAULT_FREE;
        end else begin
          if (policy == POL_FIFO || policy == POL_LRU)
            for (f = 0; f < n; f++) begin
              s = (policy == POL_FIFO) ? load_stamp[f] : last_use[f];
              if (vic < 0 || s < best) begin vic = f; best = s; end
            end
          if (vic < 0) o.status = ST_NO_VICTIM;
          else begin
            vidx = int'({fo_pid[vic], fo_page[vic]});
            pe_valid[vidx] = 1'b0; pe_frame[vidx] = '0;
            o.evicted_valid = 1'b1; o.evicted_process = fo_pid[vic];
            o.evicted_page = fo_page[vic];
            load_page(vic, r.proc_id, r.virtual_page);
            o.frame = 4'(vic); o.status = ST_FAULT_EVICT;
          end
        end
      end
    end else if (r.req_type == REQ_PERM) begin
      pe_r[idx] = r.perm_read; pe_w[idx] = r.perm_write; pe_x[idx] = r.perm_execute;
    end else if (r.req_type == REQ_FREE) begin
      for (f = 0; f < NUM_FRAMES; f++)
        if (fo_valid[f] && fo_pid[f] == r.proc_id) begin
          fo_valid[f] = 1'b0; fo_pid[f] = '0; fo_page[f] = '0;
        end
      for (f = 0; f < PAGES_PER_PROCESS; f++) begin
        vidx = int'({r.proc_id, 8'(f)});
        pe_valid[vidx] = 1'b0; pe_r[vidx] = 1'b0; pe_w[vidx] = 1'b0; pe_x[vidx] = 1'b0;
        pe_frame[vidx] = '0;
      end
    end
    if (o.status <= ST_FAULT_EVICT) o.phys_address = 20'(32'(o.frame) * 32'(pg_size));
    o.fault_count = fault_ctr;
    expected_rsps.push_back(o);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        predict_paging(req_ch.data);
        accepted++;
      end
      if (pending_reqs.size() > 0 && !hold &&
          !(src_idle_en && $urandom_range(99) < 25)) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_ch.data);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== rsp_ch.data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
            errors++;
          end
          if (e.status == ST_FAULT_EVICT) evictions++;
          if (e.status == ST_PROT) prot_faults++;
          checked++;
        end
      end
      rsp_ch.ready <= !(snk_idle_en && $urandom_range(99) < 25);
    end
  end

  function automatic req_t mk(logic [1:0] t, logic [2:0] pid, logic [7:0] pg,
                              logic [1:0] k, logic [2:0] perms);
    req_t r;
    r.req_type = t; r.proc_id = pid; r.virtual_page = pg; r.access_kind = k;
    {r.perm_read, r.perm_write, r.perm_execute} = perms;
    return r;
  endfunction

  function automatic req_t rand_req();
    int p;
    logic [1:0] t;
    p = $urandom_range(99);
    t = (p < 78) ? REQ_ACCESS : (p < 92) ? REQ_PERM : (p < 97) ? REQ_FREE : REQ_NOP;
    // a small working set keeps hits, evictions and permission checks frequent
    return mk(t, 3'($urandom_range(7)),
              ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5)),
              2'($urandom), 3'($urandom));
  endfunction

  task automatic drain(int extra);
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (req_ch.valid || expected_rsps.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] i, logic [16:0] d);
    cfg_we <= 1'b1; cfg_index <= i; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (i == REG_POLICY) policy = d[1:0];
    else if (i == REG_PAGE_SIZE) pg_size = d;
    else if (i == REG_FRAMES) nframes_reg = d[4:0];
  endtask

  initial begin
    int ph, i;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      pe_valid[i] = 1'b0; pe_r[i] = 1'b0; pe_w[i] = 1'b0; pe_x[i] = 1'b0; pe_frame[i] = '0;
    end
    for (i = 0; i < NUM_FRAMES; i++) begin
      fo_valid[i] = 1'b0; fo_pid[i] = '0; fo_page[i] = '0; last_use[i] = '0;
      load_stamp[i] = '0;
    end
    use_ctr = '0; fault_ctr = '0; policy = POL_FIFO; pg_size = 17'd4096; nframes_reg = 5'd16;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: fill, hit, protection, permissions, exec, free, odd codes
    for (i = 0; i < 5; i++)
      pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'(i), KIND_READ, 3'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd0, KIND_WRITE, 3'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd0, KIND_EXEC, 3'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd0, KIND_BAD, 3'd0));
    pending_reqs.push_back(mk(REQ_PERM, 3'd0, 8'd0, KIND_READ, 3'b001));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd0, KIND_EXEC, 3'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd0, KIND_READ, 3'd0));
    pending_reqs.push_back(mk(REQ_PERM, 3'd7, 8'd255, KIND_READ, 3'b111));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd7, 8'd255, KIND_EXEC, 3'd0));
    pending_reqs.push_back(mk(REQ_NOP, 3'd7, 8'd255, KIND_BAD, 3'b111));
    pending_reqs.push_back(mk(REQ_FREE, 3'd0, 8'd0, KIND_READ, 3'd0));
    pending_reqs.push_back(mk(REQ_ACCESS, 3'd0, 8'd1, KIND_READ, 3'd0));
    drain(30);
    // phases: policy, page size, frame count (extremes included)
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_POLICY, 17'(POL_LRU)); write_reg(REG_FRAMES, 17'd4); end
        1: begin write_reg(REG_POLICY, 17'(POL_FIFO)); write_reg(REG_PAGE_SIZE, 17'h1FFFF);
                 write_reg(REG_FRAMES, 17'd1); end
        2: begin write_reg(REG_POLICY, 17'(POL_NONE)); write_reg(REG_FRAMES, 17'd31); end
        3: begin write_reg(REG_POLICY, 17'd3); write_reg(REG_FRAMES, 17'd0);
                 write_reg(REG_PAGE_SIZE, 17'd1); end
        4: begin write_reg(REG_POLICY, 17'(POL_LRU)); write_reg(REG_FRAMES, 17'd16);
                 write_reg(REG_PAGE_SIZE, 17'd65536); end
        5: begin write_reg(REG_PAGE_SIZE, 17'($urandom)); write_reg(REG_FRAMES, 17'd8); end
        6: begin write_reg(REG_POLICY, 17'(POL_FIFO)); write_reg(REG_FRAMES, 17'd3); end
        default: begin write_reg(REG_POLICY, 17'(POL_LRU)); write_reg(REG_FRAMES, 17'd2); end
      endcase
      src_idle_en = (ph != 4);
      snk_idle_en = (ph != 4);
      for (i = 0; i < 200; i++) pending_reqs.push_back(rand_req());
      if (ph == 5) begin
        wait (pending_reqs.size() < 100);
        hold = 1;
        @(posedge clk);
        while (req_ch.valid || expected_rsps.size() != 0) @(posedge clk);
        hold = 0;
      end
      drain(300);
    end
    $display("Covered %0d requests, %0d results, %0d evictions, %0d protection faults.",
             accepted, checked, evictions, prot_faults);
    $display("Policies FIFO/LRU/none, page sizes 1..131071, frame counts 0..31.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

### sim.f
rtl/dpfm_pkg.sv
rtl/dpfm_if.sv
rtl/dpfm_cell.sv
rtl/demand_paging_frame_manager.sv
verif/dpfm_tb_if.sv
verif/tb_top.sv
